// ===== sv/mbc_pkg.sv =====
// shared types, codes and arithmetic helpers for the binaural convolver
package mbc_pkg;

	localparam int DATA_W = 24;
	localparam int ACC_W  = 64;

	// operation codes of an input beat
	localparam logic [1:0] OP_COEF   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] RND_HALF = 64'sd4194304;
	localparam logic signed [ACC_W-1:0] Q_MAX = 64'sd8388607;
	localparam logic signed [ACC_W-1:0] Q_MIN = -64'sd8388608;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic issue;
		logic mask;
		logic clear;
	} mac_ctl_t;

	// status back from the multiply-accumulate unit
	typedef struct packed {
		logic                    busy;
		logic signed [ACC_W-1:0] acc;
	} mac_stat_t;

	typedef struct packed {
		logic                     clip;
		logic signed [DATA_W-1:0] val;
	} rnd_t;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W-1:0] s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end
		return s;
	endfunction

	// round half up to q1.23 and clip
	function automatic rnd_t rnd_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] q;
		rnd_t r;
		t = sat_add(acc, RND_HALF);
		q = t >>> 23;
		r.clip = 1'b0;
		if (q > Q_MAX) begin
			r.clip = 1'b1;
			r.val  = Q_MAX[DATA_W-1:0];
		end else if (q < Q_MIN) begin
			r.clip = 1'b1;
			r.val  = Q_MIN[DATA_W-1:0];
		end else begin
			r.val = q[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/mbc_if.sv =====
// input and output channel interfaces of the binaural convolver
interface mbc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic               ear;
	logic [4:0]         speaker;
	logic [9:0]         tap;
	logic signed [23:0] data_value;
	logic               frame_end;

	modport source(output valid, operation, ear, speaker, tap, data_value, frame_end,
		input ready);
	modport sink(input valid, operation, ear, speaker, tap, data_value, frame_end,
		output ready);
endinterface

interface mbc_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] left_sample;
	logic signed [23:0] right_sample;
	logic               last;
	logic               saturated;

	modport source(output valid, left_sample, right_sample, last, saturated, input ready);
	modport sink(input valid, left_sample, right_sample, last, saturated, output ready);
endinterface

// ===== sv/mbc_store.sv =====
// coefficient memory and sample history memory, with registered read data
module mbc_store
	import mbc_pkg::*;
#(
	parameter int BLOCK    = 64,
	parameter int MAX_TAPS = 1024,
	parameter int SPEAKERS = 22,
	localparam int SpkW    = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1,
	localparam int TapW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
	localparam int RingW   = $clog2(MAX_TAPS + BLOCK),
	localparam int CoefAw  = 1 + SpkW + TapW,
	localparam int HistAw  = SpkW + RingW
) (
	input  logic                     clk,
	input  logic                     coef_we,
	input  logic [CoefAw-1:0]        coef_waddr,
	input  logic signed [DATA_W-1:0] coef_wdata,
	input  logic [CoefAw-1:0]        coef_raddr,
	output logic signed [DATA_W-1:0] coef_s1,
	input  logic                     hist_we,
	input  logic [HistAw-1:0]        hist_waddr,
	input  logic signed [DATA_W-1:0] hist_wdata,
	input  logic [HistAw-1:0]        hist_raddr,
	output logic signed [DATA_W-1:0] hist_s1
);
	logic signed [DATA_W-1:0] coef_mem [2**CoefAw];
	logic signed [DATA_W-1:0] hist_mem [2**HistAw];

	// coefficient port
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
		coef_s1 <= coef_mem[coef_raddr];
	end

	// history port
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_s1 <= hist_mem[hist_raddr];
	end
endmodule

// ===== sv/mbc_mac.sv =====
// multiply-accumulate pipeline behind the memory read stage
module mbc_mac
	import mbc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl,
	input  logic signed [DATA_W-1:0] coef_s1,
	input  logic signed [DATA_W-1:0] hist_s1,
	output mac_stat_t                stat
);
	logic                        v_s1;
	logic                        m_s1;
	logic                        v_s2;
	logic signed [2*DATA_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]     acc_q;

	// valid and mask follow the memory read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			m_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			m_s1 <= ctl.mask;
			v_s2 <= v_s1;
		end
	end

	// product, zero for history older than the last clear
	always_ff @(posedge clk) begin
		if (m_s1) begin
			prod_s2 <= coef_s1 * hist_s1;
		end else begin
			prod_s2 <= '0;
		end
	end

	// saturating accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= sat_add(acc_q, ACC_W'(prod_s2));
		end
	end

	assign stat.busy = v_s1 | v_s2;
	assign stat.acc  = acc_q;
endmodule

// ===== sv/mbc_ctrl.sv =====
// sequencer: frame capture, history writes, tap sweep and result register
module mbc_ctrl
	import mbc_pkg::*;
#(
	parameter int BLOCK    = 64,
	parameter int MAX_TAPS = 1024,
	parameter int SPEAKERS = 22,
	localparam int SpkW    = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1,
	localparam int TapW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
	localparam int RingLen = MAX_TAPS + BLOCK,
	localparam int RingW   = $clog2(RingLen),
	localparam int CoefAw  = 1 + SpkW + TapW,
	localparam int HistAw  = SpkW + RingW
) (
	input  logic                     clk,
	input  logic                     arst_n,
	mbc_in_if.sink                   in_ch,
	mbc_out_if.source                out_ch,
	input  logic                     cfg_we,
	input  logic [10:0]              cfg_data,
	output logic                     coef_we,
	output logic [CoefAw-1:0]        coef_waddr,
	output logic signed [DATA_W-1:0] coef_wdata,
	output logic [CoefAw-1:0]        coef_raddr,
	output logic                     hist_we,
	output logic [HistAw-1:0]        hist_waddr,
	output logic signed [DATA_W-1:0] hist_wdata,
	output logic [HistAw-1:0]        hist_raddr,
	output mac_ctl_t                 mac_ctl,
	input  mac_stat_t                mac_stat
);
	localparam int TcW     = $clog2(MAX_TAPS + 1);
	localparam int FillW   = $clog2(RingLen + 1);
	localparam int BlkW    = (BLOCK > 1) ? $clog2(BLOCK) : 1;
	localparam int FrmW    = $clog2(BLOCK + 1);

	state_t state_q, state_d;

	logic [10:0]              ir_q;
	logic signed [DATA_W-1:0] fb_q [SPEAKERS];
	logic [SpkW-1:0]          cnt_q;
	logic [TapW-1:0]          k_q;
	logic                     ear_q;
	logic [BlkW-1:0]          out_i_q;
	logic [FrmW-1:0]          frames_q;
	logic [RingW-1:0]         wp_q;
	logic [FillW-1:0]         fill_q;
	logic [RingW-1:0]         idx_q;
	logic [FillW-1:0]         dist_q;
	logic signed [DATA_W-1:0] left_q;
	logic                     lclip_q;
	logic                     ov_q;
	logic signed [DATA_W-1:0] ol_q;
	logic signed [DATA_W-1:0] or_q;
	logic                     olast_q;
	logic                     osat_q;

	logic             accept;
	logic             spk_ok;
	logic             tap_ok;
	logic [TcW-1:0]   taps;
	logic             last_k;
	logic             last_spk;
	logic             last_frame;
	logic             last_out;
	logic [FillW-1:0] back;
	logic [FillW-1:0] wp_e;
	logic [RingW-1:0] start_idx;
	logic [RingW-1:0] cur_idx;
	logic [RingW-1:0] nxt_idx;
	logic [FillW-1:0] cur_dist;
	logic             out_free;
	logic             drain_done;
	logic             out_load;
	rnd_t             rnd;

	// input decode
	assign accept = in_ch.valid & in_ch.ready;
	assign spk_ok = 32'(in_ch.speaker) < SPEAKERS;
	assign tap_ok = 32'(in_ch.tap) < MAX_TAPS;

	// taps in use, clamped to the supported range
	always_comb begin
		if (ir_q == '0) begin
			taps = TcW'(1);
		end else if (32'(ir_q) > MAX_TAPS) begin
			taps = TcW'(MAX_TAPS);
		end else begin
			taps = TcW'(ir_q);
		end
	end

	assign last_k     = TcW'(k_q) == taps - TcW'(1);
	assign last_spk   = 32'(cnt_q) == SPEAKERS - 1;
	assign last_frame = 32'(frames_q) == BLOCK - 1;
	assign last_out   = 32'(out_i_q) == BLOCK - 1;

	// history position of the newest tap for this output
	assign back = FillW'(BLOCK) - FillW'(out_i_q);
	assign wp_e = FillW'(wp_q);
	always_comb begin
		if (wp_e >= back) begin
			start_idx = RingW'(wp_e - back);
		end else begin
			start_idx = RingW'(wp_e + FillW'(RingLen) - back);
		end
	end

	assign cur_idx  = (k_q == '0) ? start_idx : idx_q;
	assign cur_dist = (k_q == '0) ? back : dist_q;
	assign nxt_idx  = (cur_idx == '0) ? RingW'(RingLen - 1) : cur_idx - RingW'(1);

	assign out_free   = !ov_q || out_ch.ready;
	assign drain_done = !mac_stat.busy;
	assign rnd        = rnd_sat(mac_stat.acc);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_ch.operation == OP_SAMPLE && in_ch.frame_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (last_spk) begin
					state_d = last_frame ? ST_ISSUE : ST_IDLE;
				end
			end
			ST_ISSUE: begin
				if (last_k && last_spk) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_done) begin
					state_d = ear_q ? ST_EMIT : ST_ISSUE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = last_out ? ST_IDLE : ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ch.ready   = 1'b0;
		hist_we       = 1'b0;
		mac_ctl.issue = 1'b0;
		mac_ctl.clear = 1'b0;
		mac_ctl.mask  = cur_dist <= fill_q;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE:  in_ch.ready = 1'b1;
			ST_FLUSH: hist_we = 1'b1;
			ST_ISSUE: mac_ctl.issue = 1'b1;
			ST_DRAIN: mac_ctl.clear = drain_done & ~ear_q;
			ST_EMIT: begin
				out_load      = out_free;
				mac_ctl.clear = out_free;
			end
			default: ;
		endcase
	end

	// memory addressing
	assign coef_we    = accept && in_ch.operation == OP_COEF && spk_ok && tap_ok;
	assign coef_waddr = {in_ch.ear, in_ch.speaker[SpkW-1:0], TapW'(in_ch.tap)};
	assign coef_wdata = in_ch.data_value;
	assign coef_raddr = {ear_q, cnt_q, k_q};
	assign hist_waddr = {cnt_q, wp_q};
	assign hist_wdata = fb_q[cnt_q];
	assign hist_raddr = {cnt_q, cur_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_q <= 11'd1;
		end else if (cfg_we) begin
			ir_q <= cfg_data;
		end
	end

	// frame buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SPEAKERS; s++) begin
				fb_q[s] <= '0;
			end
		end else if ((accept && in_ch.operation == OP_CLEAR) ||
			(state_q == ST_FLUSH && last_spk)) begin
			for (int s = 0; s < SPEAKERS; s++) begin
				fb_q[s] <= '0;
			end
		end else if (accept && in_ch.operation == OP_SAMPLE && spk_ok) begin
			fb_q[in_ch.speaker[SpkW-1:0]] <= in_ch.data_value;
		end
	end

	// ring pointer, fill count and block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
			wp_q     <= '0;
			fill_q   <= '0;
		end else if (accept && in_ch.operation == OP_CLEAR) begin
			frames_q <= '0;
			wp_q     <= '0;
			fill_q   <= '0;
		end else if (state_q == ST_FLUSH && last_spk) begin
			frames_q <= last_frame ? '0 : frames_q + FrmW'(1);
			wp_q     <= (32'(wp_q) == RingLen - 1) ? '0 : wp_q + RingW'(1);
			if (32'(fill_q) != RingLen) begin
				fill_q <= fill_q + FillW'(1);
			end
		end
	end

	// sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			k_q     <= '0;
			ear_q   <= 1'b0;
			out_i_q <= '0;
			idx_q   <= '0;
			dist_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					k_q     <= '0;
					ear_q   <= 1'b0;
					out_i_q <= '0;
				end
				ST_FLUSH: begin
					cnt_q <= last_spk ? '0 : cnt_q + SpkW'(1);
				end
				ST_ISSUE: begin
					idx_q  <= nxt_idx;
					dist_q <= cur_dist + FillW'(1);
					if (last_k) begin
						k_q   <= '0;
						cnt_q <= last_spk ? '0 : cnt_q + SpkW'(1);
					end else begin
						k_q <= k_q + TapW'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_done && !ear_q) begin
						ear_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ear_q   <= 1'b0;
						out_i_q <= last_out ? '0 : out_i_q + BlkW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// left ear result waits for the right one
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && drain_done && !ear_q) begin
			left_q  <= rnd.val;
			lclip_q <= rnd.clip;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ol_q    <= left_q;
			or_q    <= rnd.val;
			olast_q <= last_out;
			osat_q  <= lclip_q | rnd.clip;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.left_sample  = ol_q;
	assign out_ch.right_sample = or_q;
	assign out_ch.last         = olast_q;
	assign out_ch.saturated    = osat_q;
endmodule

// ===== sv/multichannel_binaural_convolver_core.sv =====
// Binaural convolver: SPEAKERS channels are mixed into left and right ear signals through
// per-speaker, per-ear impulse responses of ir_length taps held in a coefficient memory,
// against a ring of past frames held in a history memory. Coefficient writes, clears and
// samples that do not close a frame leave the input ready. After a sample beat with
// frame_end, no input beat is taken while the frame is written to history one speaker
// per cycle. The beat that closes every BLOCK-th frame then starts the output sweep, which
// is bound by the single multiply-accumulate unit fed by the two memory read ports: one
// product per cycle while taps are issued; no input beat is taken during the sweep.
// Results are held in an output register, so the next input beat may be taken while the
// last result still waits. No clearing pass is needed after reset or clear: a fill count
// masks history that has not been written since.
module multichannel_binaural_convolver_core
	import mbc_pkg::*;
#(
	parameter int BLOCK    = 64,
	parameter int MAX_TAPS = 1024,
	parameter int SPEAKERS = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	mbc_in_if.sink      in_ch,
	mbc_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [10:0] cfg_data
);
	localparam int SpkW   = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
	localparam int TapW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int RingW  = $clog2(MAX_TAPS + BLOCK);
	localparam int CoefAw = 1 + SpkW + TapW;
	localparam int HistAw = SpkW + RingW;

	logic                     coef_we;
	logic [CoefAw-1:0]        coef_waddr;
	logic signed [DATA_W-1:0] coef_wdata;
	logic [CoefAw-1:0]        coef_raddr;
	logic signed [DATA_W-1:0] coef_s1;
	logic                     hist_we;
	logic [HistAw-1:0]        hist_waddr;
	logic signed [DATA_W-1:0] hist_wdata;
	logic [HistAw-1:0]        hist_raddr;
	logic signed [DATA_W-1:0] hist_s1;
	mac_ctl_t                 mac_ctl;
	mac_stat_t                mac_stat;

	// sequencer
	mbc_ctrl #(.BLOCK(BLOCK), .MAX_TAPS(MAX_TAPS), .SPEAKERS(SPEAKERS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.coef_we    (coef_we),
		.coef_waddr (coef_waddr),
		.coef_wdata (coef_wdata),
		.coef_raddr (coef_raddr),
		.hist_we    (hist_we),
		.hist_waddr (hist_waddr),
		.hist_wdata (hist_wdata),
		.hist_raddr (hist_raddr),
		.mac_ctl    (mac_ctl),
		.mac_stat   (mac_stat)
	);

	// memories
	mbc_store #(.BLOCK(BLOCK), .MAX_TAPS(MAX_TAPS), .SPEAKERS(SPEAKERS)) u_store (
		.clk        (clk),
		.coef_we    (coef_we),
		.coef_waddr (coef_waddr),
		.coef_wdata (coef_wdata),
		.coef_raddr (coef_raddr),
		.coef_s1    (coef_s1),
		.hist_we    (hist_we),
		.hist_waddr (hist_waddr),
		.hist_wdata (hist_wdata),
		.hist_raddr (hist_raddr),
		.hist_s1    (hist_s1)
	);

	// multiply-accumulate
	mbc_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.coef_s1 (coef_s1),
		.hist_s1 (hist_s1),
		.stat    (mac_stat)
	);
endmodule

// ===== sv/mbc_check.sv =====
// port checker for the binaural convolver and its binding
module mbc_check
	import mbc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         in_op,
	input logic               in_frame_end,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [23:0] out_left,
	input logic signed [23:0] out_right,
	input logic               out_last,
	input logic               out_sat
);
	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_left) && $stable(out_right) &&
			$stable(out_last) && $stable(out_sat))
		else $error("result beat changed while stalled");

	// input stays ready after a beat that does not close a frame
	a_short_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_op != OP_SAMPLE || !in_frame_end) |=> in_ready)
		else $error("input stalled after a single cycle beat");

	// closing a frame writes history before the next beat
	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == OP_SAMPLE && in_frame_end |=> !in_ready)
		else $error("input taken during frame write");
endmodule

bind multichannel_binaural_convolver_core mbc_check u_mbc_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_op        (in_ch.operation),
	.in_frame_end (in_ch.frame_end),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_left     (out_ch.left_sample),
	.out_right    (out_ch.right_sample),
	.out_last     (out_ch.last),
	.out_sat      (out_ch.saturated)
);
